>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, round constants and sigma functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] HASH_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream: one byte per request, digest as eight words.
// ----------------------------------------------------------------------------
//  channel   direction  valid     stall     payload
//  input     in         i_valid   o_stall   i_data  (sha_pkg::t_in_item)
//  output    out        o_valid   i_stall   o_data  (sha_pkg::t_out_item)
//
//  a byte that does not complete a block is written into the buffer
//  the 64th byte of a block starts 64 rounds on the shared round unit,
//  one per cycle, then a fold into the hash
//  end of message: padding bytes up to the length slot at one per cycle, then
//  the length, one or two compressions, then eight digest words at one per
//  cycle while the output is not stalled
//  o_stall is high whenever the block is not idle; output stalls hold the word
//  reset (synchronous, active low) loads the initial hash and clears counters
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sha_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sha_pkg::t_out_item   o_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_w    [0:15];
    logic [31:0] r_v    [0:7];
    logic [31:0] r_hash [0:7];
    logic [63:0] r_len;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic        r_padding;
    logic        r_need80;
    logic        r_final;
    logic        r_out_valid;
    logic [2:0]  r_out_idx;

    logic        in_fire;
    logic [3:0]  wsel;
    logic [4:0]  bsel;
    logic [63:0] len_bits;
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_wnext;
    logic [31:0] choose;
    logic [31:0] major;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign in_fire  = i_valid && !o_stall;
    assign wsel     = r_fill[5:2];
    // big-endian byte lane inside the word
    assign bsel     = {~r_fill[1:0], 3'b000};
    assign len_bits = {r_len[60:0], 3'b000};

    always_comb begin
        choose  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        major   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        n_t1    = r_v[7] + sha_pkg::big_sigma1(r_v[4]) + choose
                  + sha_pkg::ROUND_K[r_round] + r_w[0];
        n_t2    = sha_pkg::big_sigma0(r_v[0]) + major;
        n_wnext = r_w[0] + sha_pkg::small_sigma0(r_w[1]) + r_w[9]
                  + sha_pkg::small_sigma1(r_w[14]);
    end

    always_comb begin
        o_data.digest_word = r_hash[r_out_idx];
        o_data.word_index  = r_out_idx;
        o_data.last_word   = (r_out_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_fill      <= '0;
            r_round     <= '0;
            r_padding   <= 1'b0;
            r_need80    <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha_pkg::HASH_INIT[i];
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_data.byte_valid) begin
                            r_w[wsel][bsel +: 8] <= i_data.data_byte;
                            r_len  <= r_len + 64'd1;
                            r_fill <= r_fill + 6'd1;
                        end
                        if (i_data.last_byte) begin
                            r_padding <= 1'b1;
                            r_need80  <= 1'b1;
                        end
                        if (i_data.byte_valid && r_fill == 6'd63) begin
                            r_state <= S_ROUND;
                            r_round <= '0;
                            for (int i = 0; i < 8; i++) begin
                                r_v[i] <= r_hash[i];
                            end
                        end else if (i_data.last_byte) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    r_v[0] <= n_t1 + n_t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + n_t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    // schedule window slides by one word per round
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[15] <= n_wnext;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    if (r_final) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                        r_out_idx   <= '0;
                    end else if (r_padding) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    if (r_need80 || r_fill != sha_pkg::LEN_POS) begin
                        r_w[wsel][bsel +: 8] <= r_need80 ? sha_pkg::PAD_MARK : 8'h00;
                        r_need80 <= 1'b0;
                        r_fill   <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_state <= S_ROUND;
                            r_round <= '0;
                            for (int i = 0; i < 8; i++) begin
                                r_v[i] <= r_hash[i];
                            end
                        end
                    end else begin
                        // length slot: bit count, big endian
                        r_w[14] <= len_bits[63:32];
                        r_w[15] <= len_bits[31:0];
                        r_fill  <= '0;
                        r_final <= 1'b1;
                        r_state <= S_ROUND;
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_hash[i];
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_out_idx == 3'd7) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                            r_len       <= '0;
                            r_fill      <= '0;
                            r_padding   <= 1'b0;
                            r_final     <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_hash[i] <= sha_pkg::HASH_INIT[i];
                            end
                        end else begin
                            r_out_idx <= r_out_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_out_only_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT)
        else $error("digest word offered outside output phase");

    a_round_on_empty_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |-> r_fill == 6'd0)
        else $error("compression running with a partly filled buffer");

    a_full_block_compresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_data.byte_valid && r_fill == 6'd63) |=> r_state == S_ROUND)
        else $error("full block did not start compression");

    a_restart_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_data.last_word) |=>
            (r_state == S_IDLE && r_len == 64'd0 && r_fill == 6'd0 && !r_padding))
        else $error("message state not cleared after last digest word");
`endif

endmodule
